FILE: design/rta_pkg.sv
`default_nettype none

package rta_pkg;

   // Default bounds on the image size, handed to the top level's parameters
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int MAX_GRADIENT   = 16;

   // Field and register widths
   localparam int DIM_W      = 13;
   localparam int LEN_W      = 5;
   localparam int CHARS_W    = 64;
   localparam int PIX_W      = 8;
   localparam int CHAR_W     = 8;
   localparam int IDX_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Rec.709 luma weights in 2^16 fixed point, full-scale luma and newline byte
   localparam int               LUMA_W     = 24;
   localparam logic [15:0]      W_RED      = 16'd13933;
   localparam logic [15:0]      W_GREEN    = 16'd46871;
   localparam logic [15:0]      W_BLUE     = 16'd4732;
   localparam logic [LUMA_W-1:0] FULL_SCALE = 24'd16711680;
   localparam logic [CHAR_W-1:0] NEWLINE    = 8'd10;

   // Register reset values
   localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 13'd1;
   localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 13'd1;
   localparam logic [DIM_W-1:0]   RST_SCALE_X      = 13'd16;
   localparam logic [DIM_W-1:0]   RST_SCALE_Y      = 13'd32;
   localparam logic [LEN_W-1:0]   RST_GRAD_LENGTH  = 5'd10;
   localparam logic [CHARS_W-1:0] RST_CHARS_LOW    = 64'h3A2D3D2B2A232540;
   localparam logic [CHARS_W-1:0] RST_CHARS_HIGH   = 64'h000000000000202E;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_SCALE_X      = 3'd2,
      CSR_SCALE_Y      = 3'd3,
      CSR_GRAD_LENGTH  = 3'd4,
      CSR_CHARS_LOW    = 3'd5,
      CSR_CHARS_HIGH   = 3'd6
   } rta_csr_type;

   typedef struct packed {
      logic [DIM_W-1:0]   image_width;
      logic [DIM_W-1:0]   image_height;
      logic [DIM_W-1:0]   scale_x;
      logic [DIM_W-1:0]   scale_y;
      logic [LEN_W-1:0]   gradient_length;
      logic [CHARS_W-1:0] chars_low;
      logic [CHARS_W-1:0] chars_high;
   } rta_cfg_type;

   // Classified pixel handed from front to back
   typedef struct packed {
      logic             has_char;
      logic             newline;
      logic             frame_end;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rta_cmd_type;

   typedef enum logic {
      SYNC_IDLE,
      SYNC_RUN
   } rta_sync_state_type;

   // Select gradient character idx out of the two character words
   function automatic logic [CHAR_W-1:0] pick_char(input logic [CHARS_W-1:0] lo,
                                                   input logic [CHARS_W-1:0] hi,
                                                   input logic [IDX_W-1:0]   idx);
      logic [2*CHARS_W-1:0] all_chars;
      all_chars = {hi, lo};
      return all_chars[{idx, 3'b000} +: CHAR_W];
   endfunction

endpackage

`default_nettype wire

FILE: design/rta_if.sv
`default_nettype none

// Pixel channel
interface rta_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// Character channel
interface rta_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_of_item;
   logic       frame_end;

   modport source (output valid, output out_char, output last_of_item, output frame_end,
                   input ready);
   modport sink   (input valid, input out_char, input last_of_item, input frame_end,
                   output ready);
endinterface

`default_nettype wire

FILE: design/rgb_to_ascii_art_unit.sv
// A pixel's first result passes the command queue, stages 1 to 3 and the output stage.
// Throughput: one pixel per cycle while the queue has room and no phase rebuild runs;
// a pixel giving a character and a newline holds the output stage for both of its results,
// absorbed by the 4-entry command queue. After each csr write the pixel port is held off
// for one remainder step per counter bit.
// Reset (synchronous, active high) clears counters, queue and pipe valids,
// and loads the registers with their documented defaults.
`default_nettype none

module rgb_to_ascii_art_unit #(
   parameter int MAX_WIDTH  = rta_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rta_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   rta_req_if.sink                              req_if,
   rta_rsp_if.source                            rsp_if,
   input  wire logic                            csr_write_en,
   input  wire logic [rta_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rta_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import rta_pkg::*;

   rta_cfg_type cfg_ff, cfg_in;
   rta_cmd_type push_cmd, head;
   logic        push, pop, full, not_empty;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (rta_csr_type'(csr_index))
            CSR_IMAGE_WIDTH:  cfg_in.image_width     = csr_write_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height    = csr_write_data[DIM_W-1:0];
            CSR_SCALE_X:      cfg_in.scale_x         = csr_write_data[DIM_W-1:0];
            CSR_SCALE_Y:      cfg_in.scale_y         = csr_write_data[DIM_W-1:0];
            CSR_GRAD_LENGTH:  cfg_in.gradient_length = csr_write_data[LEN_W-1:0];
            CSR_CHARS_LOW:    cfg_in.chars_low       = csr_write_data[CHARS_W-1:0];
            CSR_CHARS_HIGH:   cfg_in.chars_high      = csr_write_data[CHARS_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width     <= RST_IMAGE_WIDTH;
         cfg_ff.image_height    <= RST_IMAGE_HEIGHT;
         cfg_ff.scale_x         <= RST_SCALE_X;
         cfg_ff.scale_y         <= RST_SCALE_Y;
         cfg_ff.gradient_length <= RST_GRAD_LENGTH;
         cfg_ff.chars_low       <= RST_CHARS_LOW;
         cfg_ff.chars_high      <= RST_CHARS_HIGH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rta_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .cfg          (cfg_ff),
      .csr_write_en (csr_write_en),
      .queue_full   (full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   rta_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   rta_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (not_empty),
      .cmd       (head),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire

FILE: design/rta_front.sv
`default_nettype none

module rta_front #(
   parameter int MAX_WIDTH  = rta_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rta_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   rta_req_if.sink                   req_if,
   input  wire rta_pkg::rta_cfg_type cfg,
   input  wire logic                 csr_write_en,
   input  wire logic                 queue_full,
   output logic                      push,
   output rta_pkg::rta_cmd_type      push_cmd
);
   import rta_pkg::*;

   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int DW    = (CW > RW) ? CW : RW;
   localparam int CMP_W = ((DW > DIM_W) ? DW : DIM_W) + 1;
   localparam int STEP_W = (DW > 1) ? $clog2(DW) : 1;

   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      xph_ff, xph_in;
   logic [RW-1:0]      yph_ff, yph_in;

   rta_sync_state_type sync_ff, sync_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DW-1:0]      xdiv_ff, xdiv_in, ydiv_ff, ydiv_in;
   logic [DIM_W-1:0]   xrem_ff, xrem_in, yrem_ff, yrem_in;

   logic [CMP_W-1:0]   w_eff, h_eff, sx_eff, sy_eff, col_x, row_x;
   logic [DIM_W-1:0]   sx13, sy13;
   logic               accept, row_end, frame_last, row_used, has_char, nl, fe;
   logic [DIM_W:0]     xtrial, ytrial;

   // Effective register values: zero means one, large sizes clamp
   always_comb begin
      w_eff = CMP_W'(cfg.image_width);
      if (w_eff == '0) begin
         w_eff = CMP_W'(1);
      end else if (w_eff > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end
      h_eff = CMP_W'(cfg.image_height);
      if (h_eff == '0) begin
         h_eff = CMP_W'(1);
      end else if (h_eff > CMP_W'(MAX_HEIGHT)) begin
         h_eff = CMP_W'(MAX_HEIGHT);
      end
      sx13   = (cfg.scale_x == '0) ? DIM_W'(1) : cfg.scale_x;
      sy13   = (cfg.scale_y == '0) ? DIM_W'(1) : cfg.scale_y;
      sx_eff = CMP_W'(sx13);
      sy_eff = CMP_W'(sy13);
   end

   // Classify the pixel at the current position
   assign col_x      = CMP_W'(col_ff);
   assign row_x      = CMP_W'(row_ff);
   assign row_end    = col_x >= (w_eff - CMP_W'(1));
   assign frame_last = row_x >= (h_eff - CMP_W'(1));
   assign row_used   = (yph_ff == '0);
   assign has_char   = row_used && (xph_ff == '0);
   assign nl         = row_used && row_end;
   assign fe         = nl && ((row_x + sy_eff) >= h_eff);

   assign req_if.ready = (sync_ff == SYNC_IDLE) && !queue_full;
   assign accept       = req_if.valid && req_if.ready;

   // Push only pixels that cause a result
   always_comb begin
      push               = accept && (has_char || nl);
      push_cmd.has_char  = has_char;
      push_cmd.newline   = nl;
      push_cmd.frame_end = fe;
      push_cmd.red       = req_if.red;
      push_cmd.green     = req_if.green;
      push_cmd.blue      = req_if.blue;
   end

   // Position counters, phase counters and the remainder unit that
   // rebuilds the phases after a register write
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      xph_in  = xph_ff;
      yph_in  = yph_ff;
      sync_in = sync_ff;
      step_in = step_ff;
      xdiv_in = xdiv_ff;
      ydiv_in = ydiv_ff;
      xrem_in = xrem_ff;
      yrem_in = yrem_ff;
      xtrial  = {xrem_ff, xdiv_ff[DW-1]};
      ytrial  = {yrem_ff, ydiv_ff[DW-1]};

      if (accept) begin
         if (row_end) begin
            col_in = '0;
            xph_in = '0;
            if (frame_last) begin
               row_in = '0;
               yph_in = '0;
            end else begin
               row_in = row_ff + RW'(1);
               yph_in = (CMP_W'(yph_ff) + CMP_W'(1) == sy_eff) ? '0 : yph_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
            xph_in = (CMP_W'(xph_ff) + CMP_W'(1) == sx_eff) ? '0 : xph_ff + CW'(1);
         end
      end

      unique case (sync_ff)
         SYNC_IDLE: begin
            if (csr_write_en) begin
               sync_in = SYNC_RUN;
               step_in = '0;
               xdiv_in = DW'(col_ff);
               ydiv_in = DW'(row_ff);
               xrem_in = '0;
               yrem_in = '0;
            end
         end
         SYNC_RUN: begin
            // One restoring step per cycle, most significant bit first
            xrem_in = (xtrial >= {1'b0, sx13}) ? DIM_W'(xtrial - {1'b0, sx13})
                                               : xtrial[DIM_W-1:0];
            yrem_in = (ytrial >= {1'b0, sy13}) ? DIM_W'(ytrial - {1'b0, sy13})
                                               : ytrial[DIM_W-1:0];
            xdiv_in = xdiv_ff << 1;
            ydiv_in = ydiv_ff << 1;
            step_in = step_ff + STEP_W'(1);
            if (csr_write_en) begin
               step_in = '0;
               xdiv_in = DW'(col_ff);
               ydiv_in = DW'(row_ff);
               xrem_in = '0;
               yrem_in = '0;
            end else if (step_ff == STEP_W'(DW - 1)) begin
               sync_in = SYNC_IDLE;
               xph_in  = CW'(xrem_in);
               yph_in  = RW'(yrem_in);
            end
         end
         default: sync_in = SYNC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         xph_ff  <= '0;
         yph_ff  <= '0;
         sync_ff <= SYNC_IDLE;
         step_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         xph_ff  <= xph_in;
         yph_ff  <= yph_in;
         sync_ff <= sync_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      xdiv_ff <= xdiv_in;
      ydiv_ff <= ydiv_in;
      xrem_ff <= xrem_in;
      yrem_ff <= yrem_in;
   end

endmodule

`default_nettype wire

FILE: design/rta_queue.sv
`default_nettype none

module rta_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire rta_pkg::rta_cmd_type push_cmd,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      not_empty,
   output rta_pkg::rta_cmd_type      head
);
   import rta_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rta_cmd_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ff];

   // Advance the pointers with wrap at the queue depth
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: design/rta_back.sv
`default_nettype none

module rta_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rta_pkg::rta_cfg_type cfg,
   input  wire logic                 cmd_valid,
   input  wire rta_pkg::rta_cmd_type cmd,
   output logic                      pop,
   rta_rsp_if.source                 rsp_if
);
   import rta_pkg::*;

   typedef struct packed {
      logic              has_char;
      logic              newline;
      logic              frame_end;
   } rta_flags_type;

   // Stage 1: weighted components
   logic              s1_v_ff, s1_v_in;
   rta_flags_type     s1_f_ff;
   logic [LUMA_W-1:0] s1_pr_ff, s1_pg_ff, s1_pb_ff;
   // Stage 2: distance from full scale
   logic              s2_v_ff;
   rta_flags_type     s2_f_ff;
   logic [LUMA_W-1:0] s2_diff_ff;
   // Stage 3: scaled by length minus one, upper bits kept
   logic              s3_v_ff;
   rta_flags_type     s3_f_ff;
   logic [11:0]       s3_q_ff;
   // Output stage
   logic              out_v_ff, out_v_in;
   rta_flags_type     out_f_ff;
   logic [CHAR_W-1:0] out_char_ff;
   logic              sent_ff, sent_in;

   logic              advance, show_char, out_last, out_take;
   logic [LEN_W-1:0]  len_eff;
   logic [IDX_W-1:0]  len_m1, idx;
   logic [27:0]       prod;
   logic [12:0]       qsum;
   logic [4:0]        idx_raw;
   logic [LUMA_W-1:0] luma;

   // Effective gradient length
   always_comb begin
      len_eff = cfg.gradient_length;
      if (len_eff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_eff > LEN_W'(MAX_GRADIENT)) begin
         len_eff = LEN_W'(MAX_GRADIENT);
      end
      len_m1 = IDX_W'(len_eff - LEN_W'(1));
   end

   // Result shown by the output stage
   assign show_char       = out_f_ff.has_char && !sent_ff;
   assign out_last        = !(show_char && out_f_ff.newline);
   assign rsp_if.valid    = out_v_ff;
   assign rsp_if.out_char = show_char ? out_char_ff : NEWLINE;
   assign rsp_if.last_of_item = out_last;
   assign rsp_if.frame_end    = !show_char && out_f_ff.frame_end;

   assign out_take = out_v_ff && rsp_if.ready;
   assign advance  = !out_v_ff || (rsp_if.ready && out_last);
   assign pop      = advance && cmd_valid;
   assign s1_v_in  = cmd_valid;

   // Arithmetic between the stages
   always_comb begin
      luma    = LUMA_W'(s1_pr_ff + s1_pg_ff + s1_pb_ff);
      prod    = 28'(s2_diff_ff) * 28'(len_m1);
      qsum    = 13'(s3_q_ff) + 13'(s3_q_ff >> 8) + 13'd1;
      idx_raw = qsum[12:8];
      idx     = (idx_raw > 5'(len_m1)) ? len_m1 : idx_raw[IDX_W-1:0];
   end

   // Output stage: free on the last result, mark the character as sent
   always_comb begin
      out_v_in = out_v_ff;
      sent_in  = sent_ff;
      if (advance) begin
         out_v_in = s3_v_ff;
         sent_in  = 1'b0;
      end else if (out_take) begin
         sent_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         sent_ff  <= 1'b0;
      end else begin
         if (advance) begin
            s1_v_ff <= s1_v_in;
            s2_v_ff <= s1_v_ff;
            s3_v_ff <= s2_v_ff;
         end
         out_v_ff <= out_v_in;
         sent_ff  <= sent_in;
      end
   end

   // Move payload along the pipe; hold while the output stage waits
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_f_ff     <= '{has_char: cmd.has_char, newline: cmd.newline,
                          frame_end: cmd.frame_end};
         s1_pr_ff    <= LUMA_W'(W_RED) * LUMA_W'(cmd.red);
         s1_pg_ff    <= LUMA_W'(W_GREEN) * LUMA_W'(cmd.green);
         s1_pb_ff    <= LUMA_W'(W_BLUE) * LUMA_W'(cmd.blue);
         s2_f_ff     <= s1_f_ff;
         s2_diff_ff  <= FULL_SCALE - luma;
         s3_f_ff     <= s2_f_ff;
         s3_q_ff     <= prod[27:16];
         out_f_ff    <= s3_f_ff;
         out_char_ff <= pick_char(cfg.chars_low, cfg.chars_high, idx);
      end
   end

endmodule

`default_nettype wire

FILE: design/rta_checker.sv
`default_nettype none

module rta_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_char,
   input wire logic       rsp_last_of_item,
   input wire logic       rsp_frame_end,
   input wire logic       csr_write_en
);
   import rta_pkg::*;

   // Output stage is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Frame end only on a closing newline
   a_frame_end_newline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_out_char == NEWLINE && rsp_last_of_item)
      else $error("frame end on a result that is not a closing newline");

   // A character taken with more to come is followed by its newline
   a_newline_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_item
      |=> rsp_valid && rsp_out_char == NEWLINE && rsp_last_of_item)
      else $error("character not followed by its newline");

   // A register write holds off the pixel port while the phases rebuild
   a_csr_holds_req: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> !req_ready)
      else $error("pixel port ready right after a register write");

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

endmodule

bind rgb_to_ascii_art_unit rta_checker u_rta_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_out_char     (rsp_if.out_char),
   .rsp_last_of_item (rsp_if.last_of_item),
   .rsp_frame_end    (rsp_if.frame_end),
   .csr_write_en     (csr_write_en)
);

`default_nettype wire

FILE: test/tb_rgb_to_ascii_art_unit.sv
`default_nettype none

module tb_rgb_to_ascii_art_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import rta_pkg::*;

   // Idle patterns for the two channels
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [CHAR_W-1:0] glyph;
      logic              last;
      logic              frame_end;
   } ascii_result_type;

   localparam int SETTLE_CYCLES = 10;
   localparam int RANDOM_PIXELS = 1800;

   logic clock;
   logic reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   rta_req_if pixel_bus ();
   rta_rsp_if glyph_bus ();

   rgb_to_ascii_art_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (pixel_bus),
      .rsp_if         (glyph_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Shadow copy of the block's registers and raster position
   rta_cfg_type      shadow_cfg;
   logic [11:0]      shadow_col;
   logic [11:0]      shadow_row;
   ascii_result_type pending_glyphs[$];
   ascii_result_type seen_glyph;
   ascii_result_type want_glyph;

   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int recv_hold      = 0;
   int pixels_sent    = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Drive the result channel's ready: a counted hold-off first, then random stalls
   initial begin
      forever begin
         @(negedge clock);
         if (recv_hold > 0) begin
            recv_hold--;
            glyph_bus.ready <= 1'b0;
         end else begin
            glyph_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Match each result transaction against the oldest expected one
   always @(posedge clock) begin
      if (!reset && glyph_bus.valid && glyph_bus.ready) begin
         seen_glyph = '{glyph_bus.out_char, glyph_bus.last_of_item, glyph_bus.frame_end};
         if (pending_glyphs.size() == 0) begin
            $error("unexpected result: out_char %0d last_of_item %0d frame_end %0d",
                   seen_glyph.glyph, seen_glyph.last, seen_glyph.frame_end);
            mismatch_count++;
         end else begin
            want_glyph = pending_glyphs.pop_front();
            if (seen_glyph.glyph !== want_glyph.glyph) begin
               $error("out_char: expected %0d, got %0d", want_glyph.glyph, seen_glyph.glyph);
               mismatch_count++;
            end
            if (seen_glyph.last !== want_glyph.last) begin
               $error("last_of_item: expected %0d, got %0d", want_glyph.last, seen_glyph.last);
               mismatch_count++;
            end
            if (seen_glyph.frame_end !== want_glyph.frame_end) begin
               $error("frame_end: expected %0d, got %0d",
                      want_glyph.frame_end, seen_glyph.frame_end);
               mismatch_count++;
            end
         end
      end
   end

   function automatic int unsigned clamp_size(input int unsigned value, input int unsigned hi);
      if (value < 1) return 1;
      if (value > hi) return hi;
      return value;
   endfunction

   // Work out the characters one pixel produces and advance the raster position
   task automatic predict_glyphs(input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                                 input logic [PIX_W-1:0] blue);
      int unsigned      w, h, sx, sy, len, col, row, luma, darkness, idx;
      longint unsigned  scaled;
      bit               row_used, row_end, frame_last;
      ascii_result_type res;
      w          = clamp_size(32'(shadow_cfg.image_width), DEF_MAX_WIDTH);
      h          = clamp_size(32'(shadow_cfg.image_height), DEF_MAX_HEIGHT);
      sx         = clamp_size(32'(shadow_cfg.scale_x), 8191);
      sy         = clamp_size(32'(shadow_cfg.scale_y), 8191);
      len        = clamp_size(32'(shadow_cfg.gradient_length), MAX_GRADIENT);
      col        = 32'(shadow_col);
      row        = 32'(shadow_row);
      row_used   = (row % sy) == 0;
      row_end    = col >= w - 1;
      frame_last = row >= h - 1;

      if (row_used && (col % sx) == 0) begin
         luma     = 32'(W_RED) * 32'(red) + 32'(W_GREEN) * 32'(green)
                    + 32'(W_BLUE) * 32'(blue);
         darkness = 32'(FULL_SCALE) - luma;
         scaled   = 64'(darkness) * 64'(len - 1);
         idx      = 32'(scaled / 64'(FULL_SCALE));
         if (idx > len - 1) idx = len - 1;
         res.glyph     = (idx < 8) ? shadow_cfg.chars_low[idx*8 +: 8]
                                   : shadow_cfg.chars_high[(idx-8)*8 +: 8];
         res.last      = !row_end;
         res.frame_end = 1'b0;
         pending_glyphs.insert(pending_glyphs.size(), res);
      end
      if (row_used && row_end) begin
         res.glyph     = NEWLINE;
         res.last      = 1'b1;
         res.frame_end = (row + sy) >= h;
         pending_glyphs.insert(pending_glyphs.size(), res);
      end

      // Wrap the column at the row end and the row at the frame end
      if (row_end) begin
         shadow_col = '0;
         shadow_row = frame_last ? 12'd0 : 12'(row + 1);
      end else begin
         shadow_col = 12'(col + 1);
      end
   endtask

   // Offer one pixel, after random idle cycles, and hold it until accepted
   task automatic send_pixel(input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                             input logic [PIX_W-1:0] blue);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         pixel_bus.valid <= 1'b0;
      end
      @(negedge clock);
      pixel_bus.valid <= 1'b1;
      pixel_bus.red   <= red;
      pixel_bus.green <= green;
      pixel_bus.blue  <= blue;
      do @(posedge clock); while (!pixel_bus.ready);
      predict_glyphs(red, green, blue);
      pixels_sent++;
   endtask

   task automatic send_random_pixel;
      send_pixel(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
                 PIX_W'($urandom_range(255)));
   endtask

   // Drop valid, drain all expected results, then let the pipe empty
   task automatic wait_quiet;
      @(negedge clock);
      pixel_bus.valid <= 1'b0;
      while (pending_glyphs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input rta_csr_type which, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= which;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      case (which)
         CSR_IMAGE_WIDTH:  shadow_cfg.image_width     = value[DIM_W-1:0];
         CSR_IMAGE_HEIGHT: shadow_cfg.image_height    = value[DIM_W-1:0];
         CSR_SCALE_X:      shadow_cfg.scale_x         = value[DIM_W-1:0];
         CSR_SCALE_Y:      shadow_cfg.scale_y         = value[DIM_W-1:0];
         CSR_GRAD_LENGTH:  shadow_cfg.gradient_length = value[LEN_W-1:0];
         CSR_CHARS_LOW:    shadow_cfg.chars_low       = value;
         CSR_CHARS_HIGH:   shadow_cfg.chars_high      = value;
         default: ;
      endcase
   endtask

   task automatic program_image(input logic [63:0] w, input logic [63:0] h,
                                input logic [63:0] sx, input logic [63:0] sy,
                                input logic [63:0] len, input logic [63:0] lo,
                                input logic [63:0] hi);
      wait_quiet();
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_SCALE_X, sx);
      write_reg(CSR_SCALE_Y, sy);
      write_reg(CSR_GRAD_LENGTH, len);
      write_reg(CSR_CHARS_LOW, lo);
      write_reg(CSR_CHARS_HIGH, hi);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 58; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 58; end
         default:       begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
   endtask

   // Defaults after reset: one-pixel image, every pixel a character plus a final newline
   task automatic test_reset_defaults;
      set_idling(IDLE_NONE);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
   endtask

   // Gradient length of zero and above the maximum, extreme character words
   task automatic test_gradient_limits;
      program_image(64'd1, 64'd1, 64'd1, 64'd1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd0);
      program_image(64'd1, 64'd1, 64'd1, 64'd1, 64'd31, 64'h0706_0504_0302_0100,
                    64'hFF8F_0E0D_0C0B_0A09);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd254, 8'd7);
   endtask

   // Zero sizes and scales, and scales at or above the image size
   task automatic test_size_and_scale_limits;
      program_image(64'd0, 64'd0, 64'd0, 64'd0, 64'd16, 64'h4142_4344_4546_4748,
                    64'h494A_4B4C_4D4E_4F50);
      send_pixel(8'd77, 8'd200, 8'd13);
      program_image(64'd3, 64'd2, 64'd8191, 64'd4096, 64'd10, RST_CHARS_LOW, RST_CHARS_HIGH);
      repeat (6) send_random_pixel();
   endtask

   // Shrink the image under a running raster so the counters overrun and wrap
   task automatic test_counter_overrun;
      program_image(64'd8191, 64'd8191, 64'd1, 64'd1, 64'd16, 64'h3736_3534_3332_3130,
                    64'h4645_4443_4241_3938);
      repeat (5) send_random_pixel();
      wait_quiet();
      write_reg(CSR_IMAGE_WIDTH, 64'd2);
      send_random_pixel();
      wait_quiet();
      write_reg(CSR_IMAGE_HEIGHT, 64'd1);
      repeat (2) send_random_pixel();
   endtask

   // Hold the receiver off long enough to fill the block, then drain and resume
   task automatic test_backpressure;
      program_image(64'd4, 64'd3, 64'd1, 64'd1, 64'd16, {$urandom, $urandom},
                    {$urandom, $urandom});
      set_idling(IDLE_NONE);
      recv_hold = 80;
      repeat (40) send_random_pixel();
      wait_quiet();
      repeat (12) send_random_pixel();
   endtask

   // Random, mostly small images with random sampling, cycling through the idle patterns
   task automatic test_random_frames;
      int            target;
      int            phase;
      logic [63:0]   w, h, sx, sy, len;
      target = pixels_sent + RANDOM_PIXELS;
      phase  = 0;
      while (pixels_sent < target) begin
         w   = {$urandom, $urandom};
         h   = {$urandom, $urandom};
         sx  = {$urandom, $urandom};
         sy  = {$urandom, $urandom};
         len = {$urandom, $urandom};
         w[DIM_W-1:0]   = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(8191))
                                                   : DIM_W'($urandom_range(12));
         h[DIM_W-1:0]   = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(8191))
                                                   : DIM_W'($urandom_range(6));
         sx[DIM_W-1:0]  = ($urandom_range(7) == 0) ? DIM_W'($urandom_range(8191))
                                                   : DIM_W'($urandom_range(4));
         sy[DIM_W-1:0]  = ($urandom_range(7) == 0) ? DIM_W'($urandom_range(8191))
                                                   : DIM_W'($urandom_range(3));
         len[LEN_W-1:0] = LEN_W'($urandom_range(31));
         program_image(w, h, sx, sy, len, {$urandom, $urandom}, {$urandom, $urandom});
         set_idling(idle_mode_type'(phase % 4));
         repeat ($urandom_range(80, 200)) send_random_pixel();
         phase++;
      end
      set_idling(IDLE_NONE);
   endtask

   initial begin
      reset           <= 1'b1;
      pixel_bus.valid <= 1'b0;
      pixel_bus.red   <= '0;
      pixel_bus.green <= '0;
      pixel_bus.blue  <= '0;
      glyph_bus.ready <= 1'b0;
      csr_write_en    <= 1'b0;
      csr_index       <= CSR_IMAGE_WIDTH;
      csr_write_data  <= '0;
      shadow_cfg      = '{RST_IMAGE_WIDTH, RST_IMAGE_HEIGHT, RST_SCALE_X, RST_SCALE_Y,
                          RST_GRAD_LENGTH, RST_CHARS_LOW, RST_CHARS_HIGH};
      shadow_col      = '0;
      shadow_row      = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_gradient_limits();
      test_size_and_scale_limits();
      test_counter_overrun();
      test_backpressure();
      test_random_frames();

      wait_quiet();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
design/rta_pkg.sv
design/rta_if.sv
design/rta_front.sv
design/rta_queue.sv
design/rta_back.sv
design/rgb_to_ascii_art_unit.sv
design/rta_checker.sv
test/tb_rgb_to_ascii_art_unit.sv
